FILE: hw/rtl/shuffled_park_miller_rng_macros.svh
// ----------------------------------------------------------------------------
// Shuffled Park-Miller RNG assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_PARK_MILLER_RNG_MACROS_SVH
`define SHUFFLED_PARK_MILLER_RNG_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SPMR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SPMR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPMR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SPMR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/spmr_pkg.sv
// ----------------------------------------------------------------------------
// spmr_pkg
// Shared constants, types and state encoding of the shuffled LCG generator.
// ----------------------------------------------------------------------------
package spmr_pkg;

  // Shuffle table; a power of two so the bucket divisor is 2^IDX_SHIFT
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned TBL_AW        = $clog2(TABLE_ENTRIES);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LCG_W  = 31;

  // Minimal-standard LCG: x' = 16807 * x mod (2^31 - 1)
  localparam logic [LCG_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam int unsigned      MUL_W   = 15;
  localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
  localparam int unsigned      MUL_CW  = $clog2(MUL_W);

  // Warm-up: eight discarded steps, then one step per table entry
  localparam int unsigned WARM_STEPS = TABLE_ENTRIES + 8;
  localparam int unsigned WARM_CW    = $clog2(WARM_STEPS);

  // Table index is the top bits of the shuffle output
  localparam int unsigned IDX_SHIFT = LCG_W - TBL_AW;

  // Remainder unit
  localparam int unsigned DIV_CW = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [LCG_W-1:0]  RANGE_MAX  = 31'h7FFF_FFFF;

  // Request codes
  localparam logic REQ_RAW   = 1'b0;
  localparam logic REQ_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_CHECK,
    ST_WARM,
    ST_STEP,
    ST_READ,
    ST_MOD,
    ST_DONE
  } state_e;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Shuffle table access
  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [LCG_W-1:0]  wdata;
    logic              re;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: hw/rtl/spmr_lcg.sv
// ----------------------------------------------------------------------------
// spmr_lcg
// Bit-serial LCG step: multiplies by 16807 one multiplier bit per cycle,
// keeping the accumulator reduced mod 2^31-1 (doubling is a 31-bit rotate).
// ----------------------------------------------------------------------------
module spmr_lcg import spmr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LCG_W-1:0] x_i,
  output unit_stat_t       stat_o,
  output logic [LCG_W-1:0] res_o
);

  logic [LCG_W-1:0]  acc_q, acc_d;
  logic [LCG_W-1:0]  x_q;
  logic [MUL_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [LCG_W-1:0]  rot;
  logic [LCG_W:0]    sum;
  logic [LCG_W+1:0]  diff;

  // 2*acc mod M is a rotate; add the multiplicand on a set bit, reduce once
  always_comb begin
    rot   = {acc_q[LCG_W-2:0], acc_q[LCG_W-1]};
    sum   = {1'b0, rot} + (LCG_MUL[cnt_q] ? {1'b0, x_q} : '0);
    diff  = {1'b0, sum} - {2'b00, LCG_MOD};
    acc_d = diff[LCG_W+1] ? sum[LCG_W-1:0] : diff[LCG_W-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CW'(MUL_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = acc_q;

endmodule

FILE: hw/rtl/spmr_div.sv
// ----------------------------------------------------------------------------
// spmr_div
// Restoring remainder unit, one dividend bit per cycle. Divisor 2..2^31.
// ----------------------------------------------------------------------------
module spmr_div import spmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output unit_stat_t        stat_o,
  output logic [LCG_W-1:0]  rem_o
);

  logic [LCG_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] dv_q;
  logic [DATA_W-1:0] divisor_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [DATA_W-1:0] sh;
  logic [DATA_W:0]   diff;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    sh    = {rem_q, dv_q[DATA_W-1]};
    diff  = {1'b0, sh} - {1'b0, divisor_q};
    rem_d = diff[DATA_W] ? sh[LCG_W-1:0] : diff[LCG_W-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DATA_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      dv_q      <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dv_q  <= {dv_q[DATA_W-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

FILE: hw/rtl/spmr_table.sv
// ----------------------------------------------------------------------------
// spmr_table
// Shuffle table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spmr_table import spmr_pkg::*; (
  input  logic             clk_i,
  input  tbl_req_t         req_i,
  output logic [LCG_W-1:0] rdata_o
);

  logic [LCG_W-1:0] mem_q [TABLE_ENTRIES];
  logic [LCG_W-1:0] rdata_q;

  // Read returns the old entry when both ports hit the same address
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/shuffled_park_miller_rng.sv
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng
// Park-Miller minimal-standard LCG behind a 32-entry Bays-Durham shuffle.
// Flow: a raw draw is a serial LCG step plus a table read; a ranged draw adds
//   two remainder passes, and a further draw pass for each rejected value.
// Warm-up (after reset, a seed write or a zero state): +40 LCG steps.
// One request at a time; the next is taken while a result waits at the
//   output.
// Reset: seed 0, warm-up pending, output empty; table contents undefined.
// ----------------------------------------------------------------------------
`include "shuffled_park_miller_rng_macros.svh"

module shuffled_park_miller_rng import spmr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Seed register
  input  logic                     seed_we_i,
  input  logic signed [DATA_W-1:0] seed_i,
  // Request channel
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic                     req_type_i,
  input  logic signed [DATA_W-1:0] low_bound_i,
  input  logic signed [DATA_W-1:0] high_bound_i,
  // Result channel
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output logic signed [DATA_W-1:0] value_o
);

  state_e state_q, state_d;

  logic [DATA_W-1:0]  seed_q;
  logic               needs_warm_q, needs_warm_d;
  logic [LCG_W-1:0]   lcg_q, lcg_d;
  logic [LCG_W-1:0]   sout_q, sout_d;
  logic               ranged_q, ranged_d;
  logic [DATA_W-1:0]  lo_q, lo_d;
  logic [DATA_W-1:0]  x_q, x_d;
  logic [LCG_W-1:0]   limit_q, limit_d;
  logic [DATA_W-1:0]  res_q, res_d;
  logic [WARM_CW-1:0] wcnt_q, wcnt_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [DATA_W-1:0]  value_q, value_d;

  // Unit interfaces
  logic              lcg_start;
  logic [LCG_W-1:0]  lcg_x;
  logic [LCG_W-1:0]  lcg_res;
  unit_stat_t        lcg_stat;
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [LCG_W-1:0]  div_rem;
  unit_stat_t        div_stat;
  tbl_req_t          tbl_req;
  logic [LCG_W-1:0]  tbl_rdata;

  // Derived
  logic [DATA_W-1:0] span;
  logic              span_bad;
  logic [DATA_W-1:0] seed_abs;
  logic [LCG_W-1:0]  seed_mag;
  logic              warm_needed;
  logic              out_free;
  logic [TBL_AW-1:0] draw_idx;

  // Range span at acceptance: degenerate when one or fewer values or > 2^31
  assign span     = high_bound_i - low_bound_i;
  assign span_bad = span[DATA_W-1] || (span == '0);

  // Seed magnitude, saturated to the modulus, zero maps to one
  always_comb begin
    seed_abs = seed_q[DATA_W-1] ? (~seed_q + 1'b1) : seed_q;
    if (seed_abs > {1'b0, LCG_MOD}) begin
      seed_mag = LCG_MOD;
    end else if (seed_abs == '0) begin
      seed_mag = LCG_W'(1);
    end else begin
      seed_mag = seed_abs[LCG_W-1:0];
    end
  end

  assign warm_needed = needs_warm_q || (lcg_q == '0) || (sout_q == '0);
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign draw_idx    = sout_q[LCG_W-1:IDX_SHIFT];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == REQ_RAW) begin
            state_d = ST_CHECK;
          end else if (span_bad) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_LIMIT;
          end
        end
      end
      ST_LIMIT: begin
        if (div_stat.done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = warm_needed ? ST_WARM : ST_STEP;
      end
      ST_WARM: begin
        if (lcg_stat.done && (wcnt_q == '0)) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (lcg_stat.done) state_d = ST_READ;
      end
      ST_READ: begin
        if (!ranged_q) begin
          state_d = ST_DONE;
        end else if (tbl_rdata > limit_q) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_stat.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer and register updates
  always_comb begin
    req_ready_o  = 1'b0;
    lcg_start    = 1'b0;
    lcg_x        = lcg_q;
    div_start    = 1'b0;
    div_dividend = HALF_RANGE;
    div_divisor  = x_q;
    tbl_req      = '0;
    needs_warm_d = needs_warm_q;
    lcg_d        = lcg_q;
    sout_d       = sout_q;
    ranged_d     = ranged_q;
    lo_d         = lo_q;
    x_d          = x_q;
    limit_d      = limit_q;
    res_d        = res_q;
    wcnt_d       = wcnt_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    value_d      = value_q;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          lo_d     = low_bound_i;
          x_d      = span + 1'b1;
          ranged_d = (req_type_i == REQ_RANGE);
          res_d    = low_bound_i;
          if ((req_type_i == REQ_RANGE) && !span_bad) begin
            // Rejection limit needs 2^31 mod x
            div_start    = 1'b1;
            div_dividend = HALF_RANGE;
            div_divisor  = span + 1'b1;
          end
        end
      end
      ST_LIMIT: begin
        if (div_stat.done) limit_d = RANGE_MAX - div_rem;
      end
      ST_CHECK: begin
        lcg_start = 1'b1;
        if (warm_needed) begin
          lcg_x        = needs_warm_q ? seed_mag : LCG_W'(1);
          needs_warm_d = 1'b0;
          wcnt_d       = WARM_CW'(WARM_STEPS - 1);
        end else begin
          lcg_x = lcg_q;
        end
      end
      ST_WARM: begin
        if (lcg_stat.done) begin
          // Chain the next step; the last one is the draw's own step
          lcg_start = 1'b1;
          lcg_x     = lcg_res;
          if (wcnt_q < WARM_CW'(TABLE_ENTRIES)) begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = wcnt_q[TBL_AW-1:0];
            tbl_req.wdata = lcg_res;
          end
          if (wcnt_q == '0) begin
            lcg_d  = lcg_res;
            sout_d = lcg_res;
          end else begin
            wcnt_d = wcnt_q - 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (lcg_stat.done) begin
          lcg_d         = lcg_res;
          tbl_req.re    = 1'b1;
          tbl_req.raddr = draw_idx;
        end
      end
      ST_READ: begin
        // Swap: drawn entry out, fresh LCG value in
        sout_d        = tbl_rdata;
        tbl_req.we    = 1'b1;
        tbl_req.waddr = draw_idx;
        tbl_req.wdata = lcg_q;
        if (!ranged_q) begin
          res_d = {1'b0, tbl_rdata};
        end else if (tbl_rdata <= limit_q) begin
          div_start    = 1'b1;
          div_dividend = {1'b0, tbl_rdata};
          div_divisor  = x_q;
        end
      end
      ST_MOD: begin
        if (div_stat.done) res_d = lo_q + {1'b0, div_rem};
      end
      ST_DONE: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          value_d     = res_q;
        end
      end
    endcase

    // Seed write forces a fresh warm-up
    if (seed_we_i) needs_warm_d = 1'b1;
  end

  // Control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_q       <= '0;
      needs_warm_q <= 1'b1;
      lcg_q        <= '0;
      sout_q       <= '0;
      rsp_valid_q  <= 1'b0;
      wcnt_q       <= '0;
      ranged_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      needs_warm_q <= needs_warm_d;
      lcg_q        <= lcg_d;
      sout_q       <= sout_d;
      rsp_valid_q  <= rsp_valid_d;
      wcnt_q       <= wcnt_d;
      ranged_q     <= ranged_d;
      if (seed_we_i) seed_q <= seed_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    x_q     <= x_d;
    limit_q <= limit_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  spmr_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lcg_start),
    .x_i     (lcg_x),
    .stat_o  (lcg_stat),
    .res_o   (lcg_res)
  );

  spmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  spmr_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  assign rsp_valid_o = rsp_valid_q;
  assign value_o     = value_q;

  // Checks
  `SPMR_ASSERT_IMP(a_lcg_start_idle, clk_i, rst_ni, lcg_start, !lcg_stat.busy, "LCG restarted while busy")
  `SPMR_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `SPMR_ASSERT_NXT(a_read_then_swap, clk_i, rst_ni, tbl_req.re, state_q == ST_READ, "table read not followed by swap")
  `SPMR_ASSERT_IMP(a_warm_count, clk_i, rst_ni, state_q == ST_WARM, wcnt_q <= WARM_CW'(WARM_STEPS - 1), "warm-up count out of range")

endmodule
